>>> design/lcm_pkg.sv
// ----------------------------------------------------------------------------
// lcm_pkg
// shared widths and handshake structs for the lcm / gcd block
// ----------------------------------------------------------------------------
package lcm_pkg;

   localparam int OPERAND_WIDTH  = 16;
   localparam int PRODUCT_WIDTH  = 2 * OPERAND_WIDTH;
   localparam int COUNT_WIDTH    = $clog2(OPERAND_WIDTH);
   localparam int REQ_DATA_WIDTH = ((2 * OPERAND_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_WIDTH = ((3 * OPERAND_WIDTH + 7) / 8) * 8;

   // control from the stream side into the engine
   typedef struct packed {
      logic start;
      logic ack;
   } lcm_ctrl_type;

   // status from the engine back to the stream side
   typedef struct packed {
      logic idle;
      logic done;
   } lcm_status_type;

endpackage

>>> design/lcm_engine.sv
// ----------------------------------------------------------------------------
// lcm_engine
// sequencer around one shared subtractor: binary gcd, restoring division of
// the first operand by the gcd, then one multiply by the second operand
// ----------------------------------------------------------------------------
module lcm_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lcm_pkg::lcm_ctrl_type                ctrl,
   input  logic [lcm_pkg::OPERAND_WIDTH-1:0]    operand_a,
   input  logic [lcm_pkg::OPERAND_WIDTH-1:0]    operand_b,
   output lcm_pkg::lcm_status_type              status,
   output logic [lcm_pkg::PRODUCT_WIDTH-1:0]    least_multiple,
   output logic [lcm_pkg::OPERAND_WIDTH-1:0]    common_divisor
);
   import lcm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV,
      ST_MUL,
      ST_DONE
   } state_type;

   state_type                state_ff;
   logic [OPERAND_WIDTH-1:0] u_ff;
   logic [OPERAND_WIDTH-1:0] v_ff;
   logic [COUNT_WIDTH-1:0]   k_ff;
   logic [OPERAND_WIDTH-1:0] g_ff;
   logic [OPERAND_WIDTH-1:0] rem_ff;
   logic [OPERAND_WIDTH-1:0] quo_ff;
   logic [OPERAND_WIDTH-1:0] b_ff;
   logic [COUNT_WIDTH-1:0]   cnt_ff;
   logic [PRODUCT_WIDTH-1:0] lcm_ff;

   // shared subtract unit
   logic [OPERAND_WIDTH:0]   sub_x;
   logic [OPERAND_WIDTH:0]   sub_y;
   logic [OPERAND_WIDTH+1:0] sub_diff;
   logic                     borrow;

   always_comb begin
      case (state_ff)
         ST_GCD: begin
            sub_x = {1'b0, u_ff};
            sub_y = {1'b0, v_ff};
         end
         ST_DIV: begin
            sub_x = {rem_ff, quo_ff[OPERAND_WIDTH-1]};
            sub_y = {1'b0, g_ff};
         end
         default: begin
            sub_x = '0;
            sub_y = '0;
         end
      endcase
   end

   assign sub_diff = {1'b0, sub_x} - {1'b0, sub_y};
   assign borrow   = sub_diff[OPERAND_WIDTH+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (ctrl.start) begin
                  u_ff   <= operand_a;
                  v_ff   <= operand_b;
                  quo_ff <= operand_a;
                  b_ff   <= operand_b;
                  k_ff   <= '0;
                  rem_ff <= '0;
                  cnt_ff <= COUNT_WIDTH'(OPERAND_WIDTH - 1);
                  if (operand_a[OPERAND_WIDTH-1:1] == '0) begin
                     g_ff     <= OPERAND_WIDTH'(1);
                     state_ff <= ST_DIV;
                  end else if (operand_b == '0) begin
                     g_ff     <= operand_a;
                     state_ff <= ST_DIV;
                  end else begin
                     state_ff <= ST_GCD;
                  end
               end
            end
            ST_GCD: begin
               if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  k_ff <= k_ff + COUNT_WIDTH'(1);
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (sub_diff == '0) begin
                  g_ff     <= u_ff << k_ff;
                  state_ff <= ST_DIV;
               end else if (borrow) begin
                  // keep the larger value in u so the next step subtracts
                  u_ff <= v_ff;
                  v_ff <= u_ff;
               end else begin
                  u_ff <= sub_diff[OPERAND_WIDTH-1:0];
               end
            end
            ST_DIV: begin
               rem_ff <= borrow ? sub_x[OPERAND_WIDTH-1:0] : sub_diff[OPERAND_WIDTH-1:0];
               quo_ff <= {quo_ff[OPERAND_WIDTH-2:0], ~borrow};
               if (cnt_ff == '0) begin
                  state_ff <= ST_MUL;
               end else begin
                  cnt_ff <= cnt_ff - COUNT_WIDTH'(1);
               end
            end
            ST_MUL: begin
               lcm_ff   <= PRODUCT_WIDTH'(quo_ff) * PRODUCT_WIDTH'(b_ff);
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               if (ctrl.ack) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign status.idle    = (state_ff == ST_IDLE);
   assign status.done    = (state_ff == ST_DONE);
   assign least_multiple = lcm_ff;
   assign common_divisor = g_ff;

`ifndef NO_ASSERTIONS
   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GCD |-> (u_ff != '0 && v_ff != '0))
      else $error("gcd operand reached zero");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> (rem_ff < g_ff))
      else $error("division remainder not below divisor");

   a_done_divisor: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> g_ff != '0)
      else $error("zero divisor on finished beat");

   a_start_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && ctrl.start) |=> state_ff != ST_IDLE)
      else $error("start did not launch the engine");
`endif

endmodule

>>> design/lcm_two_integers.sv
// sequence: from the accepting edge to rsp_tvalid the engine runs the binary gcd (skipped when
// operand_a is below 2 or operand_b is zero), then OPERAND_WIDTH division steps, one multiply
// and the hand-over to the output register
// throughput: one beat at a time; req_tready is high only while the engine is idle,
// the finished result waits in the output register so the next beat can start
// reset: synchronous, active high; clears the sequencer and rsp_tvalid
// ----------------------------------------------------------------------------
// lcm_two_integers
// least common multiple and greatest common divisor of two unsigned operands
// ----------------------------------------------------------------------------
module lcm_two_integers (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // operand_a, operand_b
   input  logic [lcm_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // least_multiple, common_divisor
   output logic [lcm_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata
);
   import lcm_pkg::*;

   lcm_ctrl_type             ctrl;
   lcm_status_type           status;
   logic [PRODUCT_WIDTH-1:0] eng_lcm;
   logic [OPERAND_WIDTH-1:0] eng_div;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [PRODUCT_WIDTH-1:0] rsp_lcm_ff;
   logic [OPERAND_WIDTH-1:0] rsp_div_ff;

   assign req_tready = status.idle;
   assign ctrl.start = req_tvalid & status.idle;
   // hand the result over once the output register is free
   assign ctrl.ack   = status.done & (~rsp_valid_ff | rsp_tready);

   lcm_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .operand_a      (req_tdata[OPERAND_WIDTH-1:0]),
      .operand_b      (req_tdata[2*OPERAND_WIDTH-1:OPERAND_WIDTH]),
      .status         (status),
      .least_multiple (eng_lcm),
      .common_divisor (eng_div)
   );

   assign rsp_valid_in = ctrl.ack | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ack) begin
         rsp_lcm_ff <= eng_lcm;
         rsp_div_ff <= eng_div;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_WIDTH'({rsp_div_ff, rsp_lcm_ff});

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !ctrl.ack)
      else $error("result overwritten while stalled");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !status.done)
      else $error("ready while a result is pending");

   a_ack_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctrl.ack |=> rsp_valid_ff)
      else $error("handed-over result not shown");
`endif

endmodule

>>> verif/lcm_two_integers_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcm_two_integers_test
// This bench checks the lcm / gcd block through its request and response
// streams. A short table of operand pairs covers the zero, one and full-scale
// corners. Random pairs follow, mixing full-range values, values that share
// factors, and values near the limits. Every response is compared with the
// typed-in values or the bench's own Euclid model. The sender runs in bursts,
// and the receiver stalls in stretches, including one long hold-off.
// ----------------------------------------------------------------------------
module lcm_two_integers_test;

   import lcm_pkg::*;

   localparam int RANDOM_ITEMS   = 1750;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 120;
   localparam int DIRECTED_COUNT = 21;

   typedef logic [OPERAND_WIDTH-1:0] operand_type;
   typedef logic [PRODUCT_WIDTH-1:0] product_type;

   typedef struct packed {
      product_type least_multiple;
      operand_type common_divisor;
   } lcm_gcd_pair_type;

   // given = 1: expected values are typed in, otherwise they come from the model
   typedef struct packed {
      operand_type operand_a;
      operand_type operand_b;
      logic        given;
      product_type least_multiple;
      operand_type common_divisor;
   } directed_row_type;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM_HIGH,
      READY_ONE_IN_FOUR,
      READY_RANDOM_LOW
   } ready_mode_type;

   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{16'd0,      16'd0,      1'b1, 32'd0,          16'd1},
      '{16'd0,      16'd65535,  1'b1, 32'd0,          16'd1},
      '{16'd0,      16'd1,      1'b1, 32'd0,          16'd1},
      '{16'd1,      16'd0,      1'b1, 32'd0,          16'd1},
      '{16'd1,      16'd1,      1'b1, 32'd1,          16'd1},
      '{16'd1,      16'd65535,  1'b1, 32'd65535,      16'd1},
      '{16'd2,      16'd0,      1'b1, 32'd0,          16'd2},
      '{16'd65535,  16'd0,      1'b1, 32'd0,          16'd65535},
      '{16'd65535,  16'd1,      1'b1, 32'd65535,      16'd1},
      '{16'd65535,  16'd65535,  1'b1, 32'd65535,      16'd65535},
      '{16'd65535,  16'd65534,  1'b1, 32'd4294770690, 16'd1},
      '{16'd32768,  16'd16384,  1'b1, 32'd32768,      16'd16384},
      '{16'd12,     16'd18,     1'b0, 32'd0,          16'd0},
      '{16'd48,     16'd180,    1'b0, 32'd0,          16'd0},
      '{16'd40320,  16'd5040,   1'b0, 32'd0,          16'd0},
      '{16'hAAAA,   16'h5555,   1'b0, 32'd0,          16'd0},
      '{16'h5555,   16'hAAAA,   1'b0, 32'd0,          16'd0},
      '{16'd65521,  16'd65519,  1'b0, 32'd0,          16'd0},
      '{16'd2,      16'd65535,  1'b0, 32'd0,          16'd0},
      '{16'd4096,   16'd65535,  1'b0, 32'd0,          16'd0},
      '{16'h8000,   16'h0001,   1'b0, 32'd0,          16'd0}
   };

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   lcm_gcd_pair_type pending_results [$];
   lcm_gcd_pair_type oldest_pair;
   int               error_count     = 0;
   int               results_checked = 0;
   int               burst_left      = 0;
   bit               holdoff_done    = 1'b0;

   lcm_two_integers dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic operand_type euclid_divisor(input operand_type x,
                                                  input operand_type y);
      operand_type p;
      operand_type q;
      operand_type r;
      p = x;
      q = y;
      while (q != '0) begin
         r = p % q;
         p = q;
         q = r;
      end
      return p;
   endfunction

   function automatic lcm_gcd_pair_type predict_lcm_gcd(input operand_type a,
                                                        input operand_type b);
      lcm_gcd_pair_type pair;
      product_type      quotient;
      // a first operand of zero or one always reports a divisor of one
      if (a < operand_type'(2)) begin
         pair.common_divisor = operand_type'(1);
      end else begin
         pair.common_divisor = euclid_divisor(a, b);
      end
      if (a == '0 || b == '0) begin
         pair.least_multiple = '0;
      end else begin
         quotient = product_type'(a) / product_type'(pair.common_divisor);
         pair.least_multiple = quotient * product_type'(b);
      end
      return pair;
   endfunction

   // holds the beat until it is taken, then books the expected response
   task automatic offer_operands(input operand_type a, input operand_type b,
                                 input lcm_gcd_pair_type expected);
      req_tdata  <= {b, a};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pending_results.push_back(expected);
   endtask

   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 12);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_for_drain();
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      operand_type a;
      operand_type b;
      operand_type k;
      int          item;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (item = 0; item < DIRECTED_COUNT; item++) begin
         a = DIRECTED_ROWS[item].operand_a;
         b = DIRECTED_ROWS[item].operand_b;
         if (DIRECTED_ROWS[item].given) begin
            offer_operands(a, b, '{DIRECTED_ROWS[item].least_multiple,
                                   DIRECTED_ROWS[item].common_divisor});
         end else begin
            offer_operands(a, b, predict_lcm_gcd(a, b));
         end
         pace_sender();
      end
      req_tvalid <= 1'b0;
      wait_for_drain();

      for (item = 0; item < RANDOM_ITEMS; item++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               a = operand_type'($urandom);
               b = operand_type'($urandom);
            end
            4: begin
               // common factor on both sides
               k = operand_type'($urandom_range(1, 255));
               a = k * operand_type'($urandom_range(0, 255));
               b = k * operand_type'($urandom_range(0, 255));
            end
            5: begin
               a = operand_type'($urandom_range(0, 20));
               b = operand_type'($urandom_range(0, 20));
            end
            6: begin
               a = operand_type'($urandom_range(0, 1));
               b = operand_type'($urandom);
               if ($urandom_range(0, 1)) begin
                  k = a;
                  a = b;
                  b = k;
               end
            end
            7: begin
               a = operand_type'(1) << $urandom_range(0, OPERAND_WIDTH - 1);
               b = operand_type'($urandom) << $urandom_range(0, OPERAND_WIDTH - 1);
            end
            8: begin
               a = operand_type'($urandom_range(1, 255));
               b = a * operand_type'($urandom_range(1, 255));
            end
            default: begin
               a = 16'hFFFF - operand_type'($urandom_range(0, 15));
               b = 16'hFFFF - operand_type'($urandom_range(0, 15));
            end
         endcase
         offer_operands(a, b, predict_lcm_gcd(a, b));
         if (item == RANDOM_ITEMS / 2) begin
            // let everything in flight come home before going on
            req_tvalid <= 1'b0;
            wait_for_drain();
         end else begin
            pace_sender();
         end
      end
      req_tvalid <= 1'b0;

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d table rows and %0d random operand pairs, %0d responses checked",
               DIRECTED_COUNT, RANDOM_ITEMS, results_checked);
      $display("including zero and one operands, full-scale values and shared factors");
      if (error_count == 0) begin
         $display("lcm_two_integers_test: PASS");
      end else begin
         $display("lcm_two_integers_test: FAIL");
      end
      $finish;
   end

   // receiver stalls in stretches of its own, with one long hold-off
   initial begin
      ready_mode_type mode;
      int             stretch;
      int             phase;
      while (reset) begin
         @(posedge clock);
      end
      forever begin
         if (!holdoff_done && results_checked >= 300) begin
            holdoff_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLDOFF_CYCLES) @(posedge clock);
         end
         mode    = ready_mode_type'($urandom_range(0, 3));
         stretch = $urandom_range(20, 200);
         for (phase = 0; phase < stretch; phase++) begin
            case (mode)
               READY_ALWAYS:      rsp_tready <= 1'b1;
               READY_RANDOM_HIGH: rsp_tready <= ($urandom_range(0, 9) < 7);
               READY_ONE_IN_FOUR: rsp_tready <= (phase % 4 == 3);
               default:           rsp_tready <= ($urandom_range(0, 9) < 3);
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_checked++;
         if (pending_results.size() == 0) begin
            $display("%0t: response beat with nothing expected, got lcm %0d gcd %0d",
                     $time, rsp_tdata[PRODUCT_WIDTH-1:0],
                     rsp_tdata[PRODUCT_WIDTH+OPERAND_WIDTH-1:PRODUCT_WIDTH]);
            error_count++;
         end else begin
            oldest_pair = pending_results.pop_front();
            if (rsp_tdata[PRODUCT_WIDTH-1:0] !== oldest_pair.least_multiple) begin
               $display("%0t: least_multiple mismatch, expected %0d got %0d", $time,
                        oldest_pair.least_multiple, rsp_tdata[PRODUCT_WIDTH-1:0]);
               error_count++;
            end
            if (rsp_tdata[PRODUCT_WIDTH+OPERAND_WIDTH-1:PRODUCT_WIDTH]
                !== oldest_pair.common_divisor) begin
               $display("%0t: common_divisor mismatch, expected %0d got %0d", $time,
                        oldest_pair.common_divisor,
                        rsp_tdata[PRODUCT_WIDTH+OPERAND_WIDTH-1:PRODUCT_WIDTH]);
               error_count++;
            end
         end
      end
   end

   initial begin
      #(64'd10_000_000);
      $display("%0t: timed out with %0d responses outstanding", $time,
               pending_results.size());
      $display("lcm_two_integers_test: FAIL");
      $finish;
   end

endmodule
